// ----- sv/kwm_pkg.sv -----
// Shared types and codes for the k-way merge heap.
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int DEFAULT_SOURCES    = 16;
  localparam int DEFAULT_DATA_WIDTH = 32;
  localparam int FUNC_W             = 2;
  localparam int SRC_W              = 4;
  localparam int VAL_W              = 32;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPLACE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SRC_W-1:0]  source;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] removed_value;
    logic             removed_valid;
    logic [SRC_W-1:0] top_source;
    logic             heap_empty;
    logic             full_error;
  } res_t;

endpackage

// ----- sv/kwm_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/k_way_merge_heap_core.sv -----
// Top level of the k-way merge heap: control, heap memory and result register.
`timescale 1ns / 1ps

// Min-heap of (value, source) pairs for merging up to SOURCES sorted streams,
// ordered by value and then by the lower source index. One request is worked
// at a time. An insert sifts the new entry up, comparing it with its parent
// once per level it climbs; a replace sifts the new value down from the top,
// comparing it with the smaller child once per level it sinks; a remove first
// fetches the last entry and sifts it down. Each level waits for the heap
// memory, whose read ports are registered, to return both children (or the
// parent). Once the result is offered, the next request can be taken.
// The top entry is kept in a register, so the removed value and the next
// source are known without a memory read. A new request is taken while the
// previous result still waits in the output register.
module k_way_merge_heap_core #(
  parameter int SOURCES    = kwm_pkg::DEFAULT_SOURCES,
  parameter int DATA_WIDTH = kwm_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  kwm_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output kwm_pkg::res_t res
);

  import kwm_pkg::*;

  localparam int IDX_W = $clog2(SOURCES);
  localparam int CNT_W = $clog2(SOURCES + 1);
  localparam int CW    = IDX_W + 2;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [SRC_W-1:0]      source;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_UP_CMP  = 5'b00010,
    ST_DN_LOAD = 5'b00100,
    ST_DN_CMP  = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  function automatic logic ahead_of(entry_t a, entry_t b);
    if (a.value != b.value) begin
      return a.value < b.value;
    end
    return a.source < b.source;
  endfunction

  state_t                state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [IDX_W-1:0]      hole, hole_next;
  entry_t                cur, cur_next;
  entry_t                top, top_next;
  logic [DATA_WIDTH-1:0] rmv_value, rmv_value_next;
  logic                  rmv_valid, rmv_valid_next;
  logic                  full_err, full_err_next;

  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr_a, raddr_b;
  entry_t                wdata;
  logic [ENTRY_W-1:0]    rdata_a, rdata_b;
  entry_t                left_e, right_e, pick_e;

  logic                  accept;
  logic [CW-1:0]         l_w, r_w, c_w, count_w;
  logic                  l_ok, r_ok, pick_r;
  logic [IDX_W-1:0]      parent, c_idx, count_idx;

  kwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SOURCES)
  ) u_heap_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign left_e    = entry_t'(rdata_a);
  assign right_e   = entry_t'(rdata_b);
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  assign count_w   = CW'(count);
  assign count_idx = count[IDX_W-1:0];
  assign l_w       = CW'({hole, 1'b1});
  assign r_w       = l_w + CW'(1);
  assign l_ok      = l_w < count_w;
  assign r_ok      = r_w < count_w;
  assign pick_r    = r_ok && ahead_of(right_e, left_e);
  assign pick_e    = pick_r ? right_e : left_e;
  assign c_w       = pick_r ? r_w : l_w;
  assign c_idx     = c_w[IDX_W-1:0];
  assign parent    = (hole - IDX_W'(1)) >> 1;

  always_comb begin
    state_next     = state;
    count_next     = count;
    hole_next      = hole;
    cur_next       = cur;
    top_next       = top;
    rmv_value_next = rmv_value;
    rmv_valid_next = rmv_valid;
    full_err_next  = full_err;
    we             = 1'b0;
    waddr          = hole;
    wdata          = cur;
    raddr_a        = '0;
    raddr_b        = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          rmv_value_next = '0;
          rmv_valid_next = 1'b0;
          full_err_next  = 1'b0;
          state_next     = ST_EMIT;
          case (req.func)
            FUNC_INSERT: begin
              cur_next.value  = DATA_WIDTH'(req.value);
              cur_next.source = req.source;
              if (count == CNT_W'(SOURCES)) begin
                full_err_next = 1'b1;
              end else if (count == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = cur_next;
                top_next   = cur_next;
                count_next = CNT_W'(1);
              end else begin
                hole_next  = count_idx;
                raddr_a    = (count_idx - IDX_W'(1)) >> 1;
                count_next = count + CNT_W'(1);
                state_next = ST_UP_CMP;
              end
            end
            FUNC_REPLACE: begin
              if (count != '0) begin
                rmv_value_next  = top.value;
                rmv_valid_next  = 1'b1;
                cur_next.value  = DATA_WIDTH'(req.value);
                cur_next.source = top.source;
                hole_next       = '0;
                raddr_a         = IDX_W'(1);
                raddr_b         = IDX_W'(2);
                state_next      = ST_DN_CMP;
              end
            end
            FUNC_REMOVE: begin
              if (count != '0) begin
                rmv_value_next = top.value;
                rmv_valid_next = 1'b1;
                count_next     = count - CNT_W'(1);
                raddr_a        = count_idx - IDX_W'(1);
                if (count != CNT_W'(1)) begin
                  state_next = ST_DN_LOAD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_UP_CMP: begin
        if (hole == '0) begin
          we         = 1'b1;
          top_next   = cur;
          state_next = ST_EMIT;
        end else if (ahead_of(cur, left_e)) begin
          // The parent moves down into the hole and the hole climbs.
          we        = 1'b1;
          wdata     = left_e;
          hole_next = parent;
          raddr_a   = (parent - IDX_W'(1)) >> 1;
        end else begin
          we         = 1'b1;
          state_next = ST_EMIT;
        end
      end

      ST_DN_LOAD: begin
        cur_next   = left_e;
        hole_next  = '0;
        raddr_a    = IDX_W'(1);
        raddr_b    = IDX_W'(2);
        state_next = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        if (l_ok && ahead_of(pick_e, cur)) begin
          // The smaller child moves up into the hole and the hole sinks.
          we        = 1'b1;
          wdata     = pick_e;
          hole_next = c_idx;
          raddr_a   = IDX_W'({c_idx, 1'b1});
          raddr_b   = IDX_W'(CW'({c_idx, 1'b1}) + CW'(1));
          if (hole == '0) begin
            top_next = pick_e;
          end
        end else begin
          we         = 1'b1;
          state_next = ST_EMIT;
          if (hole == '0) begin
            top_next = cur;
          end
        end
      end

      ST_EMIT: begin
        if (!res_valid || !res_stall) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_EMIT && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    hole      <= hole_next;
    cur       <= cur_next;
    top       <= top_next;
    rmv_value <= rmv_value_next;
    rmv_valid <= rmv_valid_next;
    full_err  <= full_err_next;
    if (state == ST_EMIT && (!res_valid || !res_stall)) begin
      res.removed_value <= VAL_W'(rmv_value);
      res.removed_valid <= rmv_valid;
      res.top_source    <= (count != '0) ? top.source : '0;
      res.heap_empty    <= (count == '0);
      res.full_error    <= full_err;
    end
  end

`ifndef SYNTHESIS
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == FUNC_INSERT && count < CNT_W'(SOURCES))
      |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the heap");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == FUNC_REMOVE && count != '0)
      |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the heap");

  a_hole_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_CMP || state == ST_DN_CMP) |-> CNT_W'(hole) < count)
    else $error("sift position outside the filled heap");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (accept && req.func == FUNC_INSERT && count == CNT_W'(SOURCES))
      |=> full_err && count == CNT_W'(SOURCES))
    else $error("full insert changed the heap or was not flagged");
`endif

endmodule
